// ----- rtl/cbs_pkg.sv -----
`timescale 1ns / 1ps

package cbs_pkg;

    localparam int COORD_BITS = 16;
    localparam int STEP_BITS  = 16;
    localparam int T_FRAC     = 16;
    localparam int STEP_MIN   = 1024;

    localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd4096;

    // h^2 and h^3 of the parameter step
    localparam int H2_BITS   = 2 * STEP_BITS;
    localparam int H3_BITS   = 3 * STEP_BITS;
    localparam int H3_HALF   = H3_BITS / 2;

    // cubic coefficients of one lane, six times the polynomial in t
    localparam int COEF_BITS = COORD_BITS + 4;

    // forward difference registers, exact modulo 2^DIFF_BITS
    localparam int DIFF_BITS = COORD_BITS + 54;

    localparam int MUL_B_BITS = H2_BITS + 1;
    localparam int MUL_A_BITS = (COEF_BITS > MUL_B_BITS) ? COEF_BITS : MUL_B_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    // divide by 3 of the offset quotient
    localparam int DIV_U_BITS = COORD_BITS + 2;
    localparam logic [DIV_U_BITS-2:0] RECIP3 =
        (DIV_U_BITS-1)'((64'd1 << DIV_U_BITS) / 64'd3);

    localparam logic [1:0] HELD_FULL = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         new_curve;
    } t_point;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] curve_x;
        logic signed [COORD_BITS-1:0] curve_y;
        logic                         last_sample;
    } t_sample;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_STORE,
        OP_LOAD,
        OP_H2,
        OP_H3,
        OP_AXL,
        OP_AXH,
        OP_BX,
        OP_CX,
        OP_AYL,
        OP_AYH,
        OP_BY,
        OP_CY,
        OP_COMB,
        OP_STEP
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_H2,
        S_W0,
        S_H3,
        S_W1,
        S_AXL,
        S_AXH,
        S_BX,
        S_CX,
        S_AYL,
        S_AYH,
        S_BY,
        S_CY,
        S_W2,
        S_COMB,
        S_RUN
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic last_step;
        logic pipe_en;
    } t_stat;

endpackage

// ----- rtl/cbs_round.sv -----
`timescale 1ns / 1ps

module cbs_round (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [cbs_pkg::DIFF_BITS-1:0]  i_f,
    output logic signed [cbs_pkg::COORD_BITS-1:0] o_q
);
    import cbs_pkg::*;

    localparam logic signed [DIFF_BITS-1:0] ROUND_BIAS =
        DIFF_BITS'(3) <<< (3 * T_FRAC);
    localparam logic [DIV_U_BITS-1:0] DIV_OFF = DIV_U_BITS'(3) << (COORD_BITS - 1);
    localparam logic [DIV_U_BITS-1:0] THREE   = DIV_U_BITS'(3);

    logic signed [DIFF_BITS-1:0]    biased;
    logic signed [DIFF_BITS-1:0]    shifted;
    logic [DIV_U_BITS-1:0]          n_u;
    logic [DIV_U_BITS-1:0]          r_u;
    logic [DIV_U_BITS-1:0]          r_u2;
    logic [2*DIV_U_BITS-2:0]        r_prod;
    logic [DIV_U_BITS-2:0]          q0;
    logic [DIV_U_BITS-1:0]          rem;
    logic [DIV_U_BITS-2:0]          q;
    logic signed [COORD_BITS-1:0]   n_q;

    // floor of (f + 3*2^48) / 2^49, then offset to stay non-negative
    always_comb begin
        biased  = i_f + ROUND_BIAS;
        shifted = biased >>> (3 * T_FRAC + 1);
        n_u     = shifted[DIV_U_BITS-1:0] + DIV_OFF;
    end

    // reciprocal quotient is exact or one short
    always_comb begin
        q0  = r_prod[2*DIV_U_BITS-2:DIV_U_BITS];
        rem = r_u2 - (DIV_U_BITS'(q0) + (DIV_U_BITS'(q0) << 1));
        q   = (rem >= THREE) ? q0 + 1'b1 : q0;
        n_q = {~q[COORD_BITS-1], q[COORD_BITS-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u    <= n_u;
            r_u2   <= r_u;
            r_prod <= r_u * RECIP3;
            o_q    <= n_q;
        end
    end

endmodule

// ----- rtl/cbs_ctrl.sv -----
`timescale 1ns / 1ps

module cbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_new_curve,
    input  cbs_pkg::t_stat i_stat,
    output cbs_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);
    import cbs_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_held;
    logic [1:0] n_held;
    logic [1:0] held_eff;

    assign held_eff = i_new_curve ? 2'd0 : r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
        end
    end

    always_comb begin
        n_state = r_state;
        n_held  = r_held;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (held_eff == HELD_FULL) begin
                        n_state = S_H2;
                        n_held  = held_eff;
                    end else begin
                        n_held = held_eff + 2'd1;
                    end
                end
            end
            S_H2:   n_state = S_W0;
            S_W0:   n_state = S_H3;
            S_H3:   n_state = S_W1;
            S_W1:   n_state = S_AXL;
            S_AXL:  n_state = S_AXH;
            S_AXH:  n_state = S_BX;
            S_BX:   n_state = S_CX;
            S_CX:   n_state = S_AYL;
            S_AYL:  n_state = S_AYH;
            S_AYH:  n_state = S_BY;
            S_BY:   n_state = S_CY;
            S_CY:   n_state = S_W2;
            S_W2:   n_state = S_COMB;
            S_COMB: n_state = S_RUN;
            S_RUN: begin
                if (i_stat.pipe_en && i_stat.last_step) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = held_eff;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = (held_eff == HELD_FULL) ? OP_LOAD : OP_STORE;
                end
            end
            S_H2:   o_cmd.op = OP_H2;
            S_H3:   o_cmd.op = OP_H3;
            S_AXL:  o_cmd.op = OP_AXL;
            S_AXH:  o_cmd.op = OP_AXH;
            S_BX:   o_cmd.op = OP_BX;
            S_CX:   o_cmd.op = OP_CX;
            S_AYL:  o_cmd.op = OP_AYL;
            S_AYH:  o_cmd.op = OP_AYH;
            S_BY:   o_cmd.op = OP_BY;
            S_CY:   o_cmd.op = OP_CY;
            S_COMB: o_cmd.op = OP_COMB;
            S_RUN:  o_cmd.op = i_stat.pipe_en ? OP_STEP : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- rtl/cbs_dpath.sv -----
`timescale 1ns / 1ps

module cbs_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cbs_pkg::t_cmd                   i_cmd,
    output cbs_pkg::t_stat                  o_stat,
    input  cbs_pkg::t_point                 i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output cbs_pkg::t_sample                o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cbs_pkg::STEP_BITS-1:0]   i_cfg_data
);
    import cbs_pkg::*;

    logic [STEP_BITS-1:0]          r_step;
    logic [STEP_BITS-1:0]          h;
    logic [STEP_BITS-1:0]          r_t;
    logic [STEP_BITS:0]            t_next;
    logic [H2_BITS-1:0]            r_h2;
    logic [H3_BITS-1:0]            r_h3;

    logic signed [COORD_BITS-1:0]  p_new [2];
    logic signed [COORD_BITS-1:0]  r_win [2][3];
    logic signed [COEF_BITS-1:0]   r_ca [2];
    logic signed [COEF_BITS-1:0]   r_cb [2];
    logic signed [COEF_BITS-1:0]   r_cc [2];
    logic signed [COEF_BITS-1:0]   r_cd [2];
    logic signed [COEF_BITS-1:0]   n_ca [2];
    logic signed [COEF_BITS-1:0]   n_cb [2];
    logic signed [COEF_BITS-1:0]   n_cc [2];
    logic signed [COEF_BITS-1:0]   n_cd [2];

    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [DIFF_BITS-1:0]   pw;
    t_op                           r_pop;

    logic signed [DIFF_BITS-1:0]   r_ah [2];
    logic signed [DIFF_BITS-1:0]   r_bh [2];
    logic signed [DIFF_BITS-1:0]   r_ch [2];
    logic signed [DIFF_BITS-1:0]   r_f  [2];
    logic signed [DIFF_BITS-1:0]   r_d1 [2];
    logic signed [DIFF_BITS-1:0]   r_d2 [2];
    logic signed [DIFF_BITS-1:0]   r_d3 [2];

    logic                          en;
    logic                          r_v1;
    logic                          r_v2;
    logic                          r_v3;
    logic                          r_l1;
    logic                          r_l2;
    logic                          r_l3;
    logic signed [COORD_BITS-1:0]  q_x;
    logic signed [COORD_BITS-1:0]  q_y;

    assign o_cfg_ready = 1'b1;
    assign h      = (r_step < STEP_BITS'(STEP_MIN)) ? STEP_BITS'(STEP_MIN) : r_step;
    assign t_next = {1'b0, r_t} + {1'b0, h};
    assign en     = !(r_v3 && i_out_stall);

    assign o_stat.last_step = t_next[STEP_BITS];
    assign o_stat.pipe_en   = en;

    assign p_new[0] = i_in_data.point_x;
    assign p_new[1] = i_in_data.point_y;

    // six times the curve polynomial: a t^3 + b t^2 + c t + d
    always_comb begin
        logic signed [COEF_BITS-1:0] e0;
        logic signed [COEF_BITS-1:0] e1;
        logic signed [COEF_BITS-1:0] e2;
        logic signed [COEF_BITS-1:0] e3;
        logic signed [COEF_BITS-1:0] dd;
        logic signed [COEF_BITS-1:0] ss;
        for (int l = 0; l < 2; l++) begin
            e0 = COEF_BITS'(r_win[l][0]);
            e1 = COEF_BITS'(r_win[l][1]);
            e2 = COEF_BITS'(r_win[l][2]);
            e3 = COEF_BITS'(p_new[l]);
            dd = e1 - e2;
            ss = e0 + e2 - (e1 <<< 1);
            n_ca[l] = e3 - e0 + dd + (dd <<< 1);
            n_cb[l] = ss + (ss <<< 1);
            n_cc[l] = (e2 - e0) + ((e2 - e0) <<< 1);
            n_cd[l] = e0 + (e1 <<< 2) + e2;
        end
    end

    // one shared multiplier for the setup of both lanes
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_H2: begin
                mul_a = MUL_A_BITS'(h);
                mul_b = MUL_B_BITS'(h);
            end
            OP_H3: begin
                mul_a = MUL_A_BITS'(r_h2);
                mul_b = MUL_B_BITS'(h);
            end
            OP_AXL: begin
                mul_a = MUL_A_BITS'(r_ca[0]);
                mul_b = MUL_B_BITS'(r_h3[H3_HALF-1:0]);
            end
            OP_AXH: begin
                mul_a = MUL_A_BITS'(r_ca[0]);
                mul_b = MUL_B_BITS'(r_h3[H3_BITS-1:H3_HALF]);
            end
            OP_BX: begin
                mul_a = MUL_A_BITS'(r_cb[0]);
                mul_b = MUL_B_BITS'(r_h2);
            end
            OP_CX: begin
                mul_a = MUL_A_BITS'(r_cc[0]);
                mul_b = MUL_B_BITS'(h);
            end
            OP_AYL: begin
                mul_a = MUL_A_BITS'(r_ca[1]);
                mul_b = MUL_B_BITS'(r_h3[H3_HALF-1:0]);
            end
            OP_AYH: begin
                mul_a = MUL_A_BITS'(r_ca[1]);
                mul_b = MUL_B_BITS'(r_h3[H3_BITS-1:H3_HALF]);
            end
            OP_BY: begin
                mul_a = MUL_A_BITS'(r_cb[1]);
                mul_b = MUL_B_BITS'(r_h2);
            end
            OP_CY: begin
                mul_a = MUL_A_BITS'(r_cc[1]);
                mul_b = MUL_B_BITS'(h);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pw = DIFF_BITS'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            r_pop  <= OP_NONE;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            r_pop <= i_cmd.op;
            if (en) begin
                r_v1 <= (i_cmd.op == OP_STEP);
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (en) begin
            r_l1 <= o_stat.last_step;
            r_l2 <= r_l1;
            r_l3 <= r_l2;
        end

        case (i_cmd.op)
            OP_STORE: begin
                for (int l = 0; l < 2; l++) begin
                    for (int k = 0; k < 3; k++) begin
                        if (i_cmd.idx == 2'(k)) begin
                            r_win[l][k] <= p_new[l];
                        end
                    end
                end
            end
            OP_LOAD: begin
                for (int l = 0; l < 2; l++) begin
                    r_ca[l]     <= n_ca[l];
                    r_cb[l]     <= n_cb[l];
                    r_cc[l]     <= n_cc[l];
                    r_cd[l]     <= n_cd[l];
                    r_win[l][0] <= r_win[l][1];
                    r_win[l][1] <= r_win[l][2];
                    r_win[l][2] <= p_new[l];
                end
            end
            OP_COMB: begin
                r_t <= '0;
                for (int l = 0; l < 2; l++) begin
                    r_f[l]  <= DIFF_BITS'(r_cd[l]) <<< (3 * T_FRAC);
                    r_d1[l] <= r_ah[l] + (r_bh[l] <<< T_FRAC) + (r_ch[l] <<< (2 * T_FRAC));
                    r_d2[l] <= (r_ah[l] <<< 2) + (r_ah[l] <<< 1)
                               + (r_bh[l] <<< (T_FRAC + 1));
                    r_d3[l] <= (r_ah[l] <<< 2) + (r_ah[l] <<< 1);
                end
            end
            OP_STEP: begin
                r_t <= t_next[STEP_BITS-1:0];
                for (int l = 0; l < 2; l++) begin
                    r_f[l]  <= r_f[l] + r_d1[l];
                    r_d1[l] <= r_d1[l] + r_d2[l];
                    r_d2[l] <= r_d2[l] + r_d3[l];
                end
            end
            default: ;
        endcase

        // the registered product is written to its target under the registered op r_pop
        case (r_pop)
            OP_H2:  r_h2 <= r_prod[H2_BITS-1:0];
            OP_H3:  r_h3 <= r_prod[H3_BITS-1:0];
            OP_AXL: r_ah[0] <= pw;
            OP_AXH: r_ah[0] <= r_ah[0] + (pw <<< H3_HALF);
            OP_BX:  r_bh[0] <= pw;
            OP_CX:  r_ch[0] <= pw;
            OP_AYL: r_ah[1] <= pw;
            OP_AYH: r_ah[1] <= r_ah[1] + (pw <<< H3_HALF);
            OP_BY:  r_bh[1] <= pw;
            OP_CY:  r_ch[1] <= pw;
            default: ;
        endcase
    end

    cbs_round u_round_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_f   (r_f[0]),
        .o_q   (q_x)
    );

    cbs_round u_round_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_f   (r_f[1]),
        .o_q   (q_y)
    );

    assign o_out_valid            = r_v3;
    assign o_out_data.curve_x     = q_x;
    assign o_out_data.curve_y     = q_y;
    assign o_out_data.last_sample = r_l3;

endmodule

// ----- rtl/cubic_bspline_sampler.sv -----
// Uniform cubic B-spline sampler.
// Input channel (i_in_valid / o_in_stall / i_in_data): one 2D control point per
// transfer. new_curve drops the held points. The first three points of a curve
// are only stored, and the input stays open for the next point.
// Every later point closes a four-point window and yields samples at
// t = 0, step, 2*step, ... while t < 1; the final one carries last_sample.
// Output channel (o_out_valid / i_out_stall / o_out_data): one sample per transfer.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): the Q0.16 step, always
// ready, to be written only while the block is idle; steps below 1024 act as 1024.
// Setup for a window point: h^2, h^3 and the a, b, c products of both lanes on the
// shared setup multiplier, then a combine step. Then the forward difference adders
// give one sample per cycle while the output does not stall, N samples in all with
// N = ceil(65536 / step) <= 64, each sent through a 3-stage rounding pipe.
// A stall on the output freezes the rounding pipe and the sample stepping; the
// next point is taken as soon as the last sample of a window enters the pipe.
// Reset (synchronous, active low) sets the step to 4096, forgets held points
// and empties the output.
`timescale 1ns / 1ps

module cubic_bspline_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  cbs_pkg::t_point               i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cbs_pkg::t_sample              o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbs_pkg::STEP_BITS-1:0] i_cfg_data
);
    import cbs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_new_curve (i_in_data.new_curve),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    cbs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

`ifndef SYNTHESIS
    // a sample step is only issued when the rounding pipe can move
    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_STEP) |-> stat.pipe_en)
        else $error("sample step issued into a blocked pipe");

    // a point that starts a new curve is never turned into a window
    a_new_curve_stores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.new_curve) |-> (cmd.op == OP_STORE))
        else $error("new curve point did not restart the held points");

    // after the last sample of a window the input opens again
    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_STEP && stat.last_step) |=> !o_in_stall)
        else $error("input still stalled after last sample step");
`endif

endmodule

// ----- tb/sv/cubic_bspline_sampler_tb.sv -----
`timescale 1ns / 1ps

module cubic_bspline_sampler_tb;

    import cbs_pkg::*;

    typedef logic signed [127:0] t_wide;

    localparam int    T_ONE     = 65536;
    localparam int    T_INC_MIN = 1024;
    localparam int    MAX_SHOWN = 10;
    localparam int    N_ITEMS   = 320;
    localparam t_wide ONE48     = t_wide'(1) <<< 48;

    class spline_scoreboard;
        logic signed [COORD_BITS-1:0] hist_x[3];
        logic signed [COORD_BITS-1:0] hist_y[3];
        int      held;
        int      t_inc;
        t_sample samples_due[$];
        int      errors;
        int      checked;
        int      windows;
        int      settings;

        function new();
            for (int k = 0; k < 3; k++) begin
                hist_x[k] = '0;
                hist_y[k] = '0;
            end
            held     = 0;
            t_inc    = 4096;
            errors   = 0;
            checked  = 0;
            windows  = 0;
            settings = 0;
        endfunction

        function void set_t_inc(int value);
            t_inc = value;
            settings++;
        endfunction

        // exact weighted sum over 6*2^48, rounded to nearest with ties upward
        function logic signed [COORD_BITS-1:0] curve_coord(int t,
                                                           logic signed [COORD_BITS-1:0] p[4]);
            t_wide tt, ss, t2, t3, acc, num, den, q;
            t_wide w[4];
            tt   = t_wide'(t);
            ss   = t_wide'(T_ONE) - tt;
            t2   = tt * tt;
            t3   = t2 * tt;
            w[0] = ss * ss * ss;
            w[1] = t_wide'(3) * t3 - t_wide'(6) * (t2 <<< 16) + t_wide'(4) * ONE48;
            w[2] = -t_wide'(3) * t3 + t_wide'(3) * (t2 <<< 16) + t_wide'(3) * (tt <<< 32)
                   + ONE48;
            w[3] = t3;
            acc  = '0;
            for (int k = 0; k < 4; k++)
                acc = acc + w[k] * t_wide'(p[k]);
            num = acc + t_wide'(3) * ONE48;
            den = t_wide'(6) * ONE48;
            q   = num / den;
            if ((num % den) != 0 && num < 0)
                q = q - 1;
            return q[COORD_BITS-1:0];
        endfunction

        function void note_point(t_point pt);
            logic signed [COORD_BITS-1:0] px[4];
            logic signed [COORD_BITS-1:0] py[4];
            t_sample s;
            int      inc;
            int      n;
            if (pt.new_curve)
                held = 0;
            if (held < 3) begin
                hist_x[held] = pt.point_x;
                hist_y[held] = pt.point_y;
                held++;
                return;
            end
            for (int k = 0; k < 3; k++) begin
                px[k] = hist_x[k];
                py[k] = hist_y[k];
            end
            px[3] = pt.point_x;
            py[3] = pt.point_y;
            inc = (t_inc < T_INC_MIN) ? T_INC_MIN : t_inc;
            n = 0;
            for (int t = 0; t < T_ONE && n < 64; t += inc) begin
                s.curve_x     = curve_coord(t, px);
                s.curve_y     = curve_coord(t, py);
                s.last_sample = (t + inc >= T_ONE);
                samples_due   = {samples_due, s};
                n++;
            end
            windows++;
            hist_x[0] = hist_x[1];
            hist_x[1] = hist_x[2];
            hist_x[2] = pt.point_x;
            hist_y[0] = hist_y[1];
            hist_y[1] = hist_y[2];
            hist_y[2] = pt.point_y;
        endfunction

        function void check_sample(t_sample got);
            t_sample want;
            checked++;
            if (samples_due.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: sample with none due: x %0d y %0d last %0b",
                             $time, got.curve_x, got.curve_y, got.last_sample);
                return;
            end
            want = samples_due.pop_front();
            if (got.curve_x !== want.curve_x || got.curve_y !== want.curve_y ||
                got.last_sample !== want.last_sample) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: mismatch: x %0d/%0d y %0d/%0d last %0b/%0b (exp/act)",
                             $time, want.curve_x, got.curve_x, want.curve_y, got.curve_y,
                             want.last_sample, got.last_sample);
            end
        endfunction

        function int pending();
            return samples_due.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_point               in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_sample              out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [STEP_BITS-1:0] cfg_data = '0;

    spline_scoreboard sb;
    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    int sent = 0;

    cubic_bspline_sampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver side: random stall bursts, one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = 300;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            sb.check_sample(out_data);
    end

    function automatic logic signed [COORD_BITS-1:0] random_coord();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            1: return COORD_BITS'($signed($urandom_range(0, 200)) - 100);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic t_point mk_point(int x, int y, bit nc);
        t_point p;
        p.point_x   = COORD_BITS'(x);
        p.point_y   = COORD_BITS'(y);
        p.new_curve = nc;
        return p;
    endfunction

    // called and returns at a falling edge; valid stays up for a following transfer
    task automatic offer_point(t_point p);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge i_clk); while (in_stall);
        sb.note_point(p);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_t_inc(int value);
        in_valid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= STEP_BITS'(value);
        do @(posedge i_clk); while (!cfg_ready);
        sb.set_t_inc(value);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int random_t_inc();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1023);
            1: return ($urandom_range(0, 1) == 0) ? 0 : 65535;
            2: return $urandom_range(32768, 65535);
            3: return $urandom_range(8192, 32767);
            default: return $urandom_range(1024, 8191);
        endcase
    endfunction

    initial begin
        int  len;
        int  next_cfg;
        int  left;
        bit  hold_done;
        t_point p;
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corners at the reset step, a short curve, a restart mid-curve
        offer_point(mk_point(-32768, -32768, 1'b1));
        offer_point(mk_point(32767, 32767, 1'b0));
        offer_point(mk_point(-32768, 32767, 1'b0));
        offer_point(mk_point(32767, -32768, 1'b0));
        offer_point(mk_point(0, 0, 1'b0));
        offer_point(mk_point(-1, 1, 1'b0));
        offer_point(mk_point(1, -1, 1'b1));
        offer_point(mk_point(32767, 32767, 1'b0));
        offer_point(mk_point(32767, 32767, 1'b0));
        offer_point(mk_point(32767, 32767, 1'b0));
        offer_point(mk_point(-32768, -32768, 1'b1));
        offer_point(mk_point(-32768, -32768, 1'b0));
        offer_point(mk_point(-32768, -32768, 1'b0));
        offer_point(mk_point(-32768, -32768, 1'b0));

        // step clamped from zero and from just below the floor
        write_t_inc(0);
        offer_point(mk_point(100, -200, 1'b1));
        offer_point(mk_point(-300, 400, 1'b0));
        offer_point(mk_point(32767, -32768, 1'b0));
        offer_point(mk_point(-32768, 32767, 1'b0));
        write_t_inc(1023);
        offer_point(mk_point(5, -5, 1'b0));
        write_t_inc(1024);
        offer_point(mk_point(-7, 7, 1'b0));

        // large steps give two samples per window
        write_t_inc(32768);
        offer_point(mk_point(12345, -12345, 1'b0));
        write_t_inc(65535);
        offer_point(mk_point(-1, -1, 1'b0));
        write_t_inc(40000);
        offer_point(mk_point(32767, 0, 1'b0));

        next_cfg  = sent;
        hold_done = 1'b0;
        while (sent < N_ITEMS) begin
            if (sent >= next_cfg) begin
                write_t_inc(random_t_inc());
                next_cfg = sent + 40;
            end
            if (sent >= 100 && !hold_done) begin
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            idle_on = (sent < N_ITEMS - 60);
            len = $urandom_range(4, 12);
            for (int i = 0; i < len; i++) begin
                p = mk_point(random_coord(), random_coord(), i == 0);
                // occasional restart that breaks a curve
                if (i != 0 && $urandom_range(0, 11) == 0)
                    p.new_curve = 1'b1;
                offer_point(p);
            end
        end
        in_valid <= 1'b0;

        left = 20000;
        while (sb.pending() != 0 && left > 0) begin
            @(negedge i_clk);
            left--;
        end
        repeat (40) @(negedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors += sb.pending();
            $display("%0d samples never arrived", sb.pending());
        end

        $display("%0d control points, %0d windows, %0d samples checked",
                 sent, sb.windows, sb.checked);
        $display("%0d step settings written, %0d mismatches", sb.settings, sb.errors);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
